>>> rtl/core/ptww_pkg.sv
// Package with shared types, constants and the glyph width table of the word wrapper.
`timescale 1ns / 1ps
package ptww_pkg;

    localparam int WORD_MAX = 32;
    localparam int LEN_W    = $clog2(WORD_MAX + 1);
    localparam int IDX_W    = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
    localparam int WW_W     = $clog2(WORD_MAX * 10 + 1);
    localparam int LW_W     = 16;
    localparam int CNT_W    = 16;
    localparam int CHAR_W   = 7;
    localparam int LIMIT_W  = 15;
    localparam int CAP_W    = 16;

    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 15'd256;
    localparam logic [CAP_W-1:0]   OUT_CAP_RESET    = 16'd1024;

    localparam logic REG_LINE_LIMIT = 1'b0;
    localparam logic REG_OUT_CAP    = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_LF    = 7'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 7'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'd0;

    localparam logic [3:0] GLYPH_W [128] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd4, 4'd2, 4'd4, 4'd7, 4'd6, 4'd9, 4'd7, 4'd2,
        4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd7,
        4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7,
        4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd8, 4'd8, 4'd6,
        4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd10,
        4'd8, 4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6,
        4'd4, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6,
        4'd6, 4'd2, 4'd5, 4'd5, 4'd2, 4'd9, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd4, 4'd2, 4'd5, 4'd7, 4'd0
    };

    localparam logic [3:0] SPACE_W = GLYPH_W[32];

    function automatic logic [3:0] glyph_width(input logic [CHAR_W-1:0] c);
        return GLYPH_W[c];
    endfunction

    typedef enum logic [1:0] {
        EMIT_NL,
        EMIT_SP,
        EMIT_WORD,
        EMIT_CLOSE
    } ptww_emit_t;

    typedef struct packed {
        logic       load;
        logic       append;
        logic       set_open;
        logic       clr_open;
        logic       emit;
        ptww_emit_t emit_sel;
        logic       count_line;
        logic       lw_clear;
        logic       lw_add;
        logic       idx_clr;
        logic       idx_inc;
        logic       flush_hold;
        logic       clear_text;
    } ptww_cmd_t;

    typedef struct packed {
        logic is_eol;
        logic is_space;
        logic fin;
        logic word_empty;
        logic word_last;
        logic need_break;
        logic line_nz;
        logic line_open;
        logic gen_ok;
        logic out_free;
        logic hold_valid;
    } ptww_status_t;

endpackage

>>> rtl/core/ptww_datapath.sv
// Datapath of the word wrapper: word buffer, line state and result staging.
`timescale 1ns / 1ps
module ptww_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptww_pkg::ptww_cmd_t           cmd,
    output ptww_pkg::ptww_status_t        status,
    input  logic [ptww_pkg::CHAR_W-1:0]   text_char,
    input  logic                          text_end,
    input  logic [ptww_pkg::LIMIT_W-1:0]  line_limit,
    input  logic [ptww_pkg::CAP_W-1:0]    output_capacity,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ptww_pkg::CHAR_W-1:0]   out_char,
    output logic                          char_valid,
    output logic                          run_end,
    output logic                          text_done,
    output logic [ptww_pkg::CNT_W-1:0]    lines_so_far,
    output logic                          word_clipped
);
    import ptww_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              valid;
        logic              done;
        logic [CNT_W-1:0]  lines;
        logic              clip;
    } result_t;

    logic [CHAR_W-1:0] word_mem [WORD_MAX];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;

    logic [CHAR_W-1:0] char_reg;
    logic              fin_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [WW_W-1:0]   ww_reg;
    logic [LW_W-1:0]   lw_reg;
    logic [CNT_W-1:0]  lc_reg;
    logic [CNT_W-1:0]  emitted_reg;
    logic              open_reg;
    logic              clip_reg;
    logic [IDX_W-1:0]  idx_reg;

    result_t           hold_reg;
    logic              hold_valid_reg;
    result_t           out_reg;
    logic              out_run_end_reg;
    logic              out_valid_reg;

    logic [CNT_W-1:0]  lc_next;
    logic [CAP_W-1:0]  emit_lim;
    logic              do_push;
    logic              out_load;
    logic              out_free;
    result_t           new_res;

    assign lc_next  = (cmd.count_line && lc_reg != '1) ? lc_reg + 1'b1 : lc_reg;
    assign emit_lim = (output_capacity == '0) ? '0 : output_capacity - 1'b1;
    assign do_push  = cmd.emit && ((cmd.emit_sel == EMIT_CLOSE) || (emitted_reg < emit_lim));
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (do_push && hold_valid_reg) || cmd.flush_hold;

    always_comb
    begin
        new_res.lines = lc_next;
        new_res.clip  = clip_reg;
        new_res.valid = (cmd.emit_sel != EMIT_CLOSE);
        new_res.done  = (cmd.emit_sel == EMIT_CLOSE);
        unique case (cmd.emit_sel)
            EMIT_NL:    new_res.ch = CHAR_LF;
            EMIT_SP:    new_res.ch = CHAR_SPACE;
            EMIT_WORD:  new_res.ch = rd_data_reg;
            EMIT_CLOSE: new_res.ch = CHAR_NUL;
        endcase
    end

    always_comb
    begin
        priority if (cmd.idx_clr)
            rd_addr = '0;
        else if (cmd.idx_inc)
            rd_addr = idx_reg + 1'b1;
        else
            rd_addr = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && len_reg < LEN_W'(WORD_MAX))
            word_mem[len_reg[IDX_W-1:0]] <= char_reg;
        rd_data_reg <= word_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= text_char;
            fin_reg  <= text_end;
        end
        if (do_push)
            hold_reg <= new_res;
        if (out_load)
        begin
            out_reg         <= hold_reg;
            out_run_end_reg <= cmd.flush_hold;
        end
        idx_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            ww_reg         <= '0;
            lw_reg         <= '0;
            lc_reg         <= '0;
            emitted_reg    <= '0;
            open_reg       <= 1'b0;
            clip_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (do_push)
                hold_valid_reg <= 1'b1;
            else if (cmd.flush_hold)
                hold_valid_reg <= 1'b0;

            if (cmd.clear_text)
            begin
                len_reg     <= '0;
                ww_reg      <= '0;
                lw_reg      <= '0;
                lc_reg      <= '0;
                emitted_reg <= '0;
                open_reg    <= 1'b0;
                clip_reg    <= 1'b0;
            end
            else
            begin
                lc_reg <= lc_next;
                if (do_push && cmd.emit_sel != EMIT_CLOSE)
                    emitted_reg <= emitted_reg + 1'b1;
                if (cmd.set_open)
                    open_reg <= 1'b1;
                else if (cmd.clr_open)
                    open_reg <= 1'b0;
                if (cmd.append)
                begin
                    if (len_reg < LEN_W'(WORD_MAX))
                    begin
                        len_reg <= len_reg + 1'b1;
                        ww_reg  <= ww_reg + WW_W'(glyph_width(char_reg));
                    end
                    else
                        clip_reg <= 1'b1;
                end
                if (cmd.lw_clear)
                    lw_reg <= '0;
                else if (cmd.lw_add)
                begin
                    lw_reg  <= lw_reg + LW_W'(ww_reg) + LW_W'(SPACE_W);
                    len_reg <= '0;
                    ww_reg  <= '0;
                end
            end
        end
    end

    always_comb
    begin
        status.is_eol     = (char_reg == CHAR_CR) || (char_reg == CHAR_LF);
        status.is_space   = (char_reg == CHAR_SPACE);
        status.fin        = fin_reg;
        status.word_empty = (len_reg == '0);
        status.word_last  = ((LEN_W'(idx_reg) + 1'b1) == len_reg);
        status.need_break = ({1'b0, lw_reg} + (LW_W + 1)'(ww_reg)) > (LW_W + 1)'(line_limit);
        status.line_nz    = (lw_reg != '0);
        status.line_open  = open_reg;
        status.gen_ok     = !hold_valid_reg || out_free;
        status.out_free   = out_free;
        status.hold_valid = hold_valid_reg;
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_reg.ch;
    assign char_valid   = out_reg.valid;
    assign text_done    = out_reg.done;
    assign lines_so_far = out_reg.lines;
    assign word_clipped = out_reg.clip;
    assign run_end      = out_run_end_reg;

endmodule

>>> rtl/core/ptww_ctrl.sv
// Controller state machine that sequences each character through the wrap steps.
`timescale 1ns / 1ps
module ptww_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  ptww_pkg::ptww_status_t  status,
    output ptww_pkg::ptww_cmd_t     cmd
);
    import ptww_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEP,
        S_WORD,
        S_WDONE,
        S_EOL,
        S_CHKFIN,
        S_CLOSE,
        S_LAST
    } state_t;

    state_t state_reg, state_next;
    logic   ending_reg, ending_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        ending_next = ending_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_eol || status.is_space)
                    state_next = S_SEP;
                else
                begin
                    cmd.append   = 1'b1;
                    cmd.set_open = 1'b1;
                    state_next   = S_CHKFIN;
                end
            end
            S_SEP:
            begin
                cmd.idx_clr = 1'b1;
                if (status.word_empty)
                begin
                    if (status.is_eol || ending_reg)
                        state_next = S_EOL;
                    else
                    begin
                        cmd.set_open = 1'b1;
                        state_next   = S_CHKFIN;
                    end
                end
                else if (!status.line_nz)
                    state_next = S_WORD;
                else if (status.gen_ok)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = status.need_break ? EMIT_NL : EMIT_SP;
                    cmd.count_line = status.need_break;
                    cmd.lw_clear   = status.need_break;
                    state_next     = S_WORD;
                end
            end
            S_WORD:
            begin
                if (status.gen_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_WORD;
                    if (status.word_last)
                        state_next = S_WDONE;
                    else
                        cmd.idx_inc = 1'b1;
                end
            end
            S_WDONE:
            begin
                cmd.lw_add = 1'b1;
                if (status.is_eol || ending_reg)
                    state_next = S_EOL;
                else
                begin
                    cmd.set_open = 1'b1;
                    state_next   = S_CHKFIN;
                end
            end
            S_EOL:
            begin
                if (!status.line_open)
                begin
                    cmd.lw_clear = 1'b1;
                    state_next   = ending_reg ? S_CLOSE : S_CHKFIN;
                end
                else if (status.gen_ok)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EMIT_NL;
                    cmd.count_line = 1'b1;
                    cmd.clr_open   = 1'b1;
                    cmd.lw_clear   = 1'b1;
                    state_next     = ending_reg ? S_CLOSE : S_CHKFIN;
                end
            end
            S_CHKFIN:
            begin
                if (status.fin)
                begin
                    ending_next = 1'b1;
                    state_next  = S_SEP;
                end
                else
                    state_next = S_LAST;
            end
            S_CLOSE:
            begin
                if (status.gen_ok)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EMIT_CLOSE;
                    cmd.clear_text = 1'b1;
                    ending_next    = 1'b0;
                    state_next     = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!status.hold_valid)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.flush_hold = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ending_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ending_reg <= ending_next;
        end
    end

endmodule

>>> rtl/core/proportional_text_word_wrap.sv
// Top level of the proportional text word wrapper with its register port.
`timescale 1ns / 1ps
// Usage: source characters enter on the input channel (in_valid, in_stall,
// text_char, text_end), one beat per character; text_end marks the last one.
// Wrapped output leaves on the output channel (out_valid, out_stall), one beat
// per emitted character, plus one closing beat with text_done at the end of a
// text. run_end marks the last beat caused by one input character; a character
// that causes nothing yields no beat.
// A character that only joins the current word is loaded, decoded, appended
// and checked for the text end; a space that ends no word takes a separator
// step in place of the append. A space that ends a word emits a separator if
// the line holds text, then replays the buffered word from the word memory one
// character per cycle while the output path is free, through its registered
// read port. A line end adds a step that closes the line, and the last
// character of a text adds the steps that close the text. One character is
// worked on at a time. The last beat of a character passes from a one-deep
// hold stage to the output register when the work on that character ends.
// Reset clears all text state, sets line_limit to 256 and output_capacity to
// 1024. While the receiver stalls, the output beat holds and the sequencer
// waits; the input is stalled whenever a character is at work.
// Registers: line_limit at address 0, output_capacity at address 4.
module proportional_text_word_wrap (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ptww_pkg::CHAR_W-1:0]   text_char,
    input  logic                          text_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ptww_pkg::CHAR_W-1:0]   out_char,
    output logic                          char_valid,
    output logic                          run_end,
    output logic                          text_done,
    output logic [ptww_pkg::CNT_W-1:0]    lines_so_far,
    output logic                          word_clipped
);
    import ptww_pkg::*;

    logic [LIMIT_W-1:0] line_limit_reg;
    logic [CAP_W-1:0]   out_cap_reg;
    logic               cfg_write;
    ptww_cmd_t          cmd;
    ptww_status_t       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LINE_LIMIT_RESET;
            out_cap_reg    <= OUT_CAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_LINE_LIMIT: line_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_OUT_CAP:    out_cap_reg    <= pwdata[CAP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LINE_LIMIT: prdata = {{(32 - LIMIT_W){1'b0}}, line_limit_reg};
            REG_OUT_CAP:    prdata = {{(32 - CAP_W){1'b0}}, out_cap_reg};
        endcase
    end

    ptww_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ptww_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .text_char       (text_char),
        .text_end        (text_end),
        .line_limit      (line_limit_reg),
        .output_capacity (out_cap_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_char        (out_char),
        .char_valid      (char_valid),
        .run_end         (run_end),
        .text_done       (text_done),
        .lines_so_far    (lines_so_far),
        .word_clipped    (word_clipped)
    );

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> run_end)
        else $error("Closing beat is not marked as the last beat of its character.");

    a_done_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> !char_valid)
        else $error("Closing beat carries a character.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input taken again while a character is still at work.");

endmodule

>>> test/tb.sv
// Self-checking testbench for the word wrapper: directed and random bursty text in, layout predicted.
`timescale 1ns / 1ps
module tb;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_CYCLES = 600000;

    localparam logic [2:0] ADDR_LINE_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_OUT_CAP    = 3'd4;

    localparam logic [511:0] GLYPH_NIBBLES = {
        64'h0000000000000000, 64'h0000000000000000,
        64'h4247697233463527, 64'h6366666666235657,
        64'h8666666664665886, 64'h6766668a86636366,
        64'h4766665662552966, 64'h6666566666642570
    };

    typedef struct packed {
        logic [ptww_pkg::CHAR_W-1:0] ch;
        logic                        fin;
    } text_item_t;

    typedef struct packed {
        logic [ptww_pkg::CHAR_W-1:0] ch;
        logic                        cv;
        logic                        re;
        logic                        td;
        logic [ptww_pkg::CNT_W-1:0]  lines;
        logic                        clip;
    } wrap_beat_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [2:0]                  paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic [ptww_pkg::CHAR_W-1:0] text_char = '0;
    logic                        text_end  = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ptww_pkg::CHAR_W-1:0] out_char;
    logic                        char_valid;
    logic                        run_end;
    logic                        text_done;
    logic [ptww_pkg::CNT_W-1:0]  lines_so_far;
    logic                        word_clipped;

    text_item_t pending_items[$];
    text_item_t next_item;
    wrap_beat_t run_beats[$];
    wrap_beat_t beats_due[$];
    wrap_beat_t got_beat;
    wrap_beat_t want_beat;

    int items_queued = 0;
    int items_taken  = 0;
    int error_count  = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    int mode_left    = 0;
    int stall_mode   = 0;
    logic hold_req   = 1'b0;
    logic hold_used  = 1'b0;

    logic [ptww_pkg::LIMIT_W-1:0] lim_cfg = ptww_pkg::LINE_LIMIT_RESET;
    logic [ptww_pkg::CAP_W-1:0]   cap_cfg = ptww_pkg::OUT_CAP_RESET;
    logic [ptww_pkg::CHAR_W-1:0]  wbuf [ptww_pkg::WORD_MAX];
    int unsigned wlen       = 0;
    int unsigned wwid       = 0;
    int unsigned lwid       = 0;
    int unsigned line_total = 0;
    int unsigned emitted    = 0;
    logic        open_line  = 1'b0;
    logic        clipped    = 1'b0;

    proportional_text_word_wrap i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_char    (text_char),
        .text_end     (text_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .char_valid   (char_valid),
        .run_end      (run_end),
        .text_done    (text_done),
        .lines_so_far (lines_so_far),
        .word_clipped (word_clipped)
    );

    function automatic int unsigned glyph(input logic [ptww_pkg::CHAR_W-1:0] c);
        return 32'(GLYPH_NIBBLES[(127 - int'(c)) * 4 +: 4]);
    endfunction

    function automatic void add_beat(input logic [ptww_pkg::CHAR_W-1:0] ch, input logic cv,
                                     input logic td);
        wrap_beat_t b;
        b.ch    = ch;
        b.cv    = cv;
        b.re    = 1'b0;
        b.td    = td;
        b.lines = line_total[ptww_pkg::CNT_W-1:0];
        b.clip  = clipped;
        run_beats.push_back(b);
    endfunction

    function automatic void put_char(input logic [ptww_pkg::CHAR_W-1:0] ch);
        int unsigned room;
        room = (cap_cfg != 0) ? cap_cfg - 16'd1 : 0;
        if (emitted < room)
        begin
            emitted++;
            add_beat(ch, 1'b1, 1'b0);
        end
    endfunction

    function automatic void bump_lines();
        if (line_total < 65535)
            line_total++;
    endfunction

    function automatic void place_word();
        int i;
        if (wlen == 0)
            return;
        if (lwid != 0)
        begin
            if (lwid + wwid > lim_cfg)
            begin
                lwid = 0;
                bump_lines();
                put_char(ptww_pkg::CHAR_LF);
            end
            else
                put_char(ptww_pkg::CHAR_SPACE);
        end
        for (i = 0; i < wlen; i++)
            put_char(wbuf[i]);
        lwid = lwid + wwid + glyph(ptww_pkg::CHAR_SPACE);
        wlen = 0;
        wwid = 0;
    endfunction

    function automatic void close_line();
        place_word();
        if (open_line)
        begin
            bump_lines();
            put_char(ptww_pkg::CHAR_LF);
            open_line = 1'b0;
        end
        lwid = 0;
    endfunction

    function automatic void wrap_step(input logic [ptww_pkg::CHAR_W-1:0] ch, input logic fin);
        wrap_beat_t b;
        run_beats.delete();
        if (ch == ptww_pkg::CHAR_CR || ch == ptww_pkg::CHAR_LF)
            close_line();
        else if (ch == ptww_pkg::CHAR_SPACE)
        begin
            place_word();
            open_line = 1'b1;
        end
        else
        begin
            open_line = 1'b1;
            if (wlen < ptww_pkg::WORD_MAX)
            begin
                wbuf[wlen] = ch;
                wlen++;
                wwid += glyph(ch);
            end
            else
                clipped = 1'b1;
        end
        if (fin)
        begin
            close_line();
            add_beat(ptww_pkg::CHAR_NUL, 1'b0, 1'b1);
            wlen       = 0;
            wwid       = 0;
            lwid       = 0;
            line_total = 0;
            emitted    = 0;
            open_line  = 1'b0;
            clipped    = 1'b0;
        end
        if (run_beats.size() > 0)
        begin
            b    = run_beats.pop_back();
            b.re = 1'b1;
            run_beats.push_back(b);
        end
        foreach (run_beats[k])
            beats_due.push_back(run_beats[k]);
    endfunction

    function automatic void note_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, what);
    endfunction

    task automatic queue_item(input logic [ptww_pkg::CHAR_W-1:0] ch, input logic fin);
        text_item_t it;
        it.ch  = ch;
        it.fin = fin;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LINE_LIMIT)
            lim_cfg = data[ptww_pkg::LIMIT_W-1:0];
        else
            cap_cfg = data[ptww_pkg::CAP_W-1:0];
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (items_taken != items_queued || beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic gen_text(input int n_items, input bit long_word);
        int left;
        int wl;
        int k;
        logic [ptww_pkg::CHAR_W-1:0] c;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_item(7'($urandom_range(127)), 1'b0);
                left--;
            end
            else
            begin
                if (long_word || $urandom_range(24) == 0)
                    wl = ptww_pkg::WORD_MAX + $urandom_range(1, 4);
                else
                    wl = $urandom_range(1, 7);
                long_word = 1'b0;
                for (k = 0; k < wl; k++)
                begin
                    if ($urandom_range(7) == 0)
                        c = 7'($urandom_range(127));
                    else
                        c = 7'($urandom_range(33, 126));
                    queue_item(c, 1'b0);
                end
                left -= wl;
                case ($urandom_range(7))
                    0: queue_item(ptww_pkg::CHAR_LF, 1'b0);
                    1: queue_item(ptww_pkg::CHAR_CR, 1'b0);
                    2:
                    begin
                        queue_item(ptww_pkg::CHAR_CR, 1'b0);
                        queue_item(ptww_pkg::CHAR_LF, 1'b0);
                        left--;
                    end
                    3:
                    begin
                        queue_item(ptww_pkg::CHAR_SPACE, 1'b0);
                        queue_item(ptww_pkg::CHAR_SPACE, 1'b0);
                        left--;
                    end
                    default: queue_item(ptww_pkg::CHAR_SPACE, 1'b0);
                endcase
                left--;
            end
        end
        queue_item(7'($urandom_range(127)), 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left > 0 || pending_items.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_item = pending_items.pop_front();
                in_valid  <= 1'b1;
                text_char <= next_item.ch;
                text_end  <= next_item.fin;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(3);
                mode_left  = $urandom_range(20, 120);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(3) == 0);
                2:       out_stall <= ($urandom_range(9) < 6);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got_beat = {out_char, char_valid, run_end, text_done, lines_so_far, word_clipped};
                if (beats_due.size() == 0)
                    note_error($sformatf({"unexpected beat: char %0d valid %b run_end %b ",
                        "done %b lines %0d clip %b"},
                        out_char, char_valid, run_end, text_done, lines_so_far, word_clipped));
                else
                begin
                    want_beat = beats_due.pop_front();
                    if (got_beat.ch !== want_beat.ch || got_beat.cv !== want_beat.cv
                        || got_beat.re !== want_beat.re || got_beat.td !== want_beat.td
                        || got_beat.lines !== want_beat.lines || got_beat.clip !== want_beat.clip)
                        note_error($sformatf({"beat mismatch: expected char %0d valid %b run_end %b ",
                            "done %b lines %0d clip %b, got char %0d valid %b run_end %b done %b ",
                            "lines %0d clip %b"},
                            want_beat.ch, want_beat.cv, want_beat.re, want_beat.td, want_beat.lines,
                            want_beat.clip, got_beat.ch, got_beat.cv, got_beat.re, got_beat.td,
                            got_beat.lines, got_beat.clip));
                end
            end
            if (in_valid && !in_stall)
            begin
                wrap_step(text_char, text_end);
                items_taken++;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_item(7'd72, 1'b0);
        queue_item(7'd105, 1'b0);
        queue_item(ptww_pkg::CHAR_SPACE, 1'b0);
        queue_item(7'd127, 1'b0);
        queue_item(ptww_pkg::CHAR_NUL, 1'b0);
        queue_item(ptww_pkg::CHAR_LF, 1'b0);
        queue_item(ptww_pkg::CHAR_CR, 1'b0);
        queue_item(ptww_pkg::CHAR_LF, 1'b0);
        queue_item(ptww_pkg::CHAR_SPACE, 1'b0);
        queue_item(ptww_pkg::CHAR_SPACE, 1'b0);
        queue_item(ptww_pkg::CHAR_CR, 1'b0);
        queue_item(7'd126, 1'b0);
        queue_item(7'd9, 1'b0);
        queue_item(ptww_pkg::CHAR_SPACE, 1'b0);
        queue_item(7'd87, 1'b1);
        queue_item(7'd120, 1'b0);
        queue_item(ptww_pkg::CHAR_SPACE, 1'b1);
        queue_item(7'd121, 1'b0);
        queue_item(ptww_pkg::CHAR_LF, 1'b1);
        queue_item(ptww_pkg::CHAR_NUL, 1'b1);
        queue_item(ptww_pkg::CHAR_CR, 1'b1);
        wait_idle();

        reg_write(ADDR_LINE_LIMIT, 32'd0);
        reg_write(ADDR_OUT_CAP, 32'd65535);
        gen_text(20, 1'b1);
        gen_text(10, 1'b0);
        wait_idle();

        reg_write(ADDR_LINE_LIMIT, 32'd32767);
        reg_write(ADDR_OUT_CAP, 32'd1);
        gen_text(15, 1'b0);
        gen_text(10, 1'b0);
        wait_idle();

        reg_write(ADDR_LINE_LIMIT, 32'd24);
        reg_write(ADDR_OUT_CAP, 32'd0);
        gen_text(15, 1'b0);
        wait_idle();

        reg_write(ADDR_LINE_LIMIT, 32'd40);
        reg_write(ADDR_OUT_CAP, 32'd12);
        gen_text(20, 1'b0);
        gen_text(10, 1'b0);
        wait_idle();

        reg_write(ADDR_LINE_LIMIT, 32'd60);
        reg_write(ADDR_OUT_CAP, 32'd1024);
        hold_req <= 1'b1;
        gen_text(30, 1'b0);
        wait_idle();

        reg_write(ADDR_LINE_LIMIT, 32'($urandom_range(8, 120)));
        reg_write(ADDR_OUT_CAP, 32'($urandom_range(20, 2000)));
        gen_text(20, 1'b1);
        gen_text(10, 1'b0);
        wait_idle();

        reg_write(ADDR_LINE_LIMIT, 32'd256);
        reg_write(ADDR_OUT_CAP, 32'd1024);
        gen_text(15, 1'b0);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
